>>> hw/rtl/mtfp_pkg.sv
package mtfp_pkg;

    // parse phases of one response message
    typedef enum logic [1:0] {
        PH_CMD   = 2'd0,
        PH_HDR   = 2'd1,
        PH_FLD   = 2'd2,
        PH_DRAIN = 2'd3
    } phase_t;

    // end-of-message status codes
    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_SHORT   = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    // result kinds
    localparam logic KIND_FIELD  = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // configuration register indexes and reset values
    localparam logic       REG_FULL_SET   = 1'b0;
    localparam logic       REG_SELECTIVE  = 1'b1;
    localparam logic [7:0] FULL_SET_RESET = 8'd47;
    localparam logic [7:0] SELECTIVE_RESET = 8'd51;

    // mask width and queue geometry
    localparam int MASK_W  = 32;
    localparam int Q_DEPTH = 4;
    localparam int Q_PTR_W = 2;
    localparam int Q_CNT_W = 3;

    // one queue entry: up to a field result and a status result
    typedef struct packed {
        logic        has_field;
        logic [4:0]  field_index;
        logic [31:0] field_raw;
        logic [2:0]  field_bytes;
        logic        has_status;
        logic [1:0]  status;
    } entry_t;

    // byte size of each defined field, 0 for undefined slots
    function automatic logic [2:0] size_of(input logic [4:0] idx);
        logic [2:0] sz;
        case (idx)
            5'd0, 5'd1, 5'd4, 5'd7, 5'd8:  sz = 3'd2;
            5'd2, 5'd3, 5'd5, 5'd6:        sz = 3'd4;
            5'd9, 5'd10, 5'd11, 5'd12:     sz = 3'd4;
            5'd13, 5'd14, 5'd15:           sz = 3'd4;
            5'd16, 5'd17, 5'd18:           sz = 3'd1;
            5'd19, 5'd20, 5'd21:           sz = 3'd4;
            default:                       sz = 3'd0;
        endcase
        return sz;
    endfunction

endpackage

>>> hw/rtl/mtfp_msg_if.sv
interface mtfp_msg_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;
    logic       end_of_message;

    modport source (output valid, output rx_byte, output end_of_message, input ready);
    modport sink (input valid, input rx_byte, input end_of_message, output ready);
endinterface

>>> hw/rtl/mtfp_res_if.sv
interface mtfp_res_if;
    logic        valid;
    logic        ready;
    logic        result_kind;
    logic [4:0]  field_index;
    logic [31:0] field_raw;
    logic [2:0]  field_bytes;
    logic [1:0]  message_status;
    logic        last_result;

    modport source (
        output valid, output result_kind, output field_index, output field_raw,
        output field_bytes, output message_status, output last_result, input ready
    );
    modport sink (
        input valid, input result_kind, input field_index, input field_raw,
        input field_bytes, input message_status, input last_result, output ready
    );
endinterface

>>> hw/rtl/masked_telemetry_field_parser.sv
// channel   dir   payload                                            per request
// msg       in    rx_byte, end_of_message                            one message byte
// res       out   result_kind, field_index, field_raw, field_bytes,  one result
//                 message_status, last_result
//
// one byte is taken per cycle while the four-entry result queue has room
// a byte that completes a field and ends the message gives two results,
// so its queue entry stays at the head until both results are taken
// the parse state and the field search settle within the accepting cycle
// reset clears parse state, the queue and restores both command codes
// the result side stalls alone; msg.ready drops only once the queue fills
module masked_telemetry_field_parser
    import mtfp_pkg::*;
#(
    parameter int FIELD_COUNT = 22
) (
    input  logic        clk,
    input  logic        rst_n,
    mtfp_msg_if.sink    msg,
    mtfp_res_if.source  res,
    input  logic        cfg_we,
    input  logic        cfg_index,
    input  logic [7:0]  cfg_data
);

    logic   q_push, q_full, q_valid, q_pop;
    entry_t q_in, q_head;

    // byte classification and field assembly
    mtfp_front #(
        .FIELD_COUNT(FIELD_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (q_in)
    );

    // decoupling queue
    mtfp_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_in),
        .full       (q_full),
        .head_valid (q_valid),
        .head_entry (q_head),
        .pop        (q_pop)
    );

    // result delivery
    mtfp_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (q_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .res        (res)
    );

endmodule

>>> hw/rtl/mtfp_front.sv
module mtfp_front
    import mtfp_pkg::*;
#(
    parameter int FIELD_COUNT = 22
) (
    input  logic         clk,
    input  logic         rst_n,
    mtfp_msg_if.sink     msg,
    input  logic         cfg_we,
    input  logic         cfg_index,
    input  logic [7:0]   cfg_data,
    input  logic         q_full,
    output logic         q_push,
    output entry_t       q_entry
);

    phase_t        phase_reg, phase_next;
    logic [31:0]   mask_reg, mask_next;
    logic [1:0]    mask_cnt_reg, mask_cnt_next;
    logic [4:0]    cur_reg, cur_next;
    logic [1:0]    fcnt_reg, fcnt_next;
    logic [31:0]   acc_reg, acc_next;
    logic          ign_reg, ign_next;
    logic [7:0]    full_code_reg, sel_code_reg;

    logic          accept;
    logic [MASK_W-1:0] defined;
    logic [MASK_W-1:0] search_mask;
    logic [MASK_W-1:0] cand;
    logic [MASK_W-1:0] above;
    logic [4:0]    enc_idx;
    logic          enc_found;
    logic [2:0]    sz;
    logic [31:0]   acc_v;
    logic [1:0]    status_v;
    logic          start;
    entry_t        ent;

    assign msg.ready = !q_full;
    assign accept    = msg.valid && !q_full;

    // fields that exist under the configured field count
    always_comb
    begin
        for (int i = 0; i < MASK_W; i++)
        begin
            defined[i] = (i < FIELD_COUNT) && (size_of(5'(i)) != 3'd0);
        end
    end

    assign above = (32'hFFFF_FFFF << cur_reg) << 1;
    assign sz    = size_of(cur_reg);
    assign acc_v = {acc_reg[23:0], msg.rx_byte};

    // search set: after the current field while in fields, the new mask in the header, else all fields
    always_comb
    begin
        if (phase_reg == PH_FLD)
        begin
            search_mask = mask_reg & above;
        end
        else if (phase_reg == PH_HDR)
        begin
            search_mask = {mask_reg[23:0], msg.rx_byte};
        end
        else
        begin
            search_mask = 32'hFFFF_FFFF;
        end
    end

    assign cand = search_mask & defined;

    // lowest present field of the candidate set
    always_comb
    begin
        enc_idx = 5'd0;
        for (int i = MASK_W - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                enc_idx = 5'(i);
            end
        end
    end
    assign enc_found = |cand;

    // byte classification and next state
    always_comb
    begin
        phase_next    = phase_reg;
        mask_next     = mask_reg;
        mask_cnt_next = mask_cnt_reg;
        cur_next      = cur_reg;
        fcnt_next     = fcnt_reg;
        acc_next      = acc_reg;
        ign_next      = ign_reg;
        status_v      = ST_OK;
        start         = 1'b0;
        ent           = '0;

        unique case (phase_reg)
            PH_CMD:
            begin
                ign_next      = 1'b0;
                mask_next     = '0;
                mask_cnt_next = 2'd0;
                if (msg.rx_byte == sel_code_reg)
                begin
                    phase_next = PH_HDR;
                    if (msg.end_of_message)
                    begin
                        status_v = ST_SHORT;
                    end
                end
                else if (msg.rx_byte == full_code_reg)
                begin
                    mask_next = 32'hFFFF_FFFF;
                    start     = 1'b1;
                end
                else
                begin
                    ign_next   = 1'b1;
                    phase_next = PH_DRAIN;
                end
            end
            PH_HDR:
            begin
                mask_next = {mask_reg[23:0], msg.rx_byte};
                if (mask_cnt_reg == 2'd3)
                begin
                    mask_cnt_next = 2'd0;
                    start         = 1'b1;
                end
                else
                begin
                    mask_cnt_next = mask_cnt_reg + 2'd1;
                    if (msg.end_of_message)
                    begin
                        status_v = ST_SHORT;
                    end
                end
            end
            PH_FLD:
            begin
                if (sz == 3'd0 || ({1'b0, fcnt_reg} + 3'd1) >= sz)
                begin
                    ent.has_field   = 1'b1;
                    ent.field_index = cur_reg;
                    ent.field_raw   = acc_v;
                    ent.field_bytes = sz;
                    fcnt_next       = 2'd0;
                    acc_next        = '0;
                    if (enc_found)
                    begin
                        cur_next = enc_idx;
                    end
                    else
                    begin
                        phase_next = PH_DRAIN;
                        cur_next   = 5'd0;
                    end
                end
                else
                begin
                    fcnt_next = fcnt_reg + 2'd1;
                    acc_next  = acc_v;
                end
            end
            PH_DRAIN:
            begin
            end
            default:
            begin
            end
        endcase

        // first present field after the header or the full-set command
        if (start)
        begin
            fcnt_next = 2'd0;
            acc_next  = '0;
            if (enc_found)
            begin
                phase_next = PH_FLD;
                cur_next   = enc_idx;
            end
            else
            begin
                phase_next = PH_DRAIN;
                cur_next   = 5'd0;
            end
        end

        // end of message closes everything
        if (msg.end_of_message)
        begin
            ent.has_status = 1'b1;
            ent.status     = ign_next ? ST_IGNORED : status_v;
            phase_next     = PH_CMD;
            mask_next      = '0;
            mask_cnt_next  = 2'd0;
            cur_next       = 5'd0;
            fcnt_next      = 2'd0;
            acc_next       = '0;
            ign_next       = 1'b0;
        end
    end

    assign q_push  = accept && (ent.has_field || ent.has_status);
    assign q_entry = ent;

    // parse state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_CMD;
            mask_reg     <= '0;
            mask_cnt_reg <= 2'd0;
            cur_reg      <= 5'd0;
            fcnt_reg     <= 2'd0;
            acc_reg      <= '0;
            ign_reg      <= 1'b0;
        end
        else if (accept)
        begin
            phase_reg    <= phase_next;
            mask_reg     <= mask_next;
            mask_cnt_reg <= mask_cnt_next;
            cur_reg      <= cur_next;
            fcnt_reg     <= fcnt_next;
            acc_reg      <= acc_next;
            ign_reg      <= ign_next;
        end
    end

    // command code registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            full_code_reg <= FULL_SET_RESET;
            sel_code_reg  <= SELECTIVE_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_index == REG_FULL_SET)
            begin
                full_code_reg <= cfg_data;
            end
            if (cfg_index == REG_SELECTIVE)
            begin
                sel_code_reg <= cfg_data;
            end
        end
    end

endmodule

>>> hw/rtl/mtfp_queue.sv
module mtfp_queue
    import mtfp_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   push,
    input  entry_t push_entry,
    output logic   full,
    output logic   head_valid,
    output entry_t head_entry,
    input  logic   pop
);

    entry_t               mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   wr_reg, rd_reg;
    logic [Q_CNT_W-1:0]   cnt_reg, cnt_next;

    assign full       = (cnt_reg == Q_CNT_W'(Q_DEPTH));
    assign head_valid = (cnt_reg != '0);
    assign head_entry = mem[rd_reg];

    // occupancy
    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop)
        begin
            cnt_next = cnt_reg + Q_CNT_W'(1);
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - Q_CNT_W'(1);
        end
    end

    // pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
            begin
                wr_reg <= wr_reg + Q_PTR_W'(1);
            end
            if (pop)
            begin
                rd_reg <= rd_reg + Q_PTR_W'(1);
            end
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_entry;
        end
    end

endmodule

>>> hw/rtl/mtfp_back.sv
module mtfp_back
    import mtfp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       head_valid,
    input  entry_t     head_entry,
    output logic       pop,
    mtfp_res_if.source res
);

    logic half_reg;
    logic show_field;
    logic fire;

    assign show_field = head_entry.has_field && !half_reg;
    assign fire       = head_valid && res.ready;

    // present the field part first, then the status part
    always_comb
    begin
        res.valid = head_valid;
        if (show_field)
        begin
            res.result_kind    = KIND_FIELD;
            res.field_index    = head_entry.field_index;
            res.field_raw      = head_entry.field_raw;
            res.field_bytes    = head_entry.field_bytes;
            res.message_status = ST_OK;
            res.last_result    = !head_entry.has_status;
        end
        else
        begin
            res.result_kind    = KIND_STATUS;
            res.field_index    = 5'd0;
            res.field_raw      = 32'd0;
            res.field_bytes    = 3'd0;
            res.message_status = head_entry.status;
            res.last_result    = 1'b1;
        end
    end

    assign pop = fire && !(show_field && head_entry.has_status);

    // tracks a field part already delivered
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg <= 1'b0;
        end
        else if (fire)
        begin
            half_reg <= show_field && head_entry.has_status;
        end
    end

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
    import mtfp_pkg::*;

    localparam int NUM_FIELDS = 22;
    localparam int NO_FIELD = 32;
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_LIMIT = 20000;
    localparam int SETTLE_CYCLES = 12;
    localparam int REPORT_LIMIT = 40;

    // one expected output result
    typedef struct packed {
        logic        kind;
        logic [4:0]  index;
        logic [31:0] raw;
        logic [2:0]  nbytes;
        logic [1:0]  status;
        logic        last;
    } parsed_t;

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic cfg_index;
    logic [7:0] cfg_data;

    mtfp_msg_if msg_ch ();
    mtfp_res_if res_ch ();

    masked_telemetry_field_parser #(
        .FIELD_COUNT (NUM_FIELDS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .msg       (msg_ch),
        .res       (res_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // parser state mirror, reset values
    logic [7:0]  full_code = FULL_SET_RESET;
    logic [7:0]  sel_code = SELECTIVE_RESET;
    phase_t      parse_at = PH_CMD;
    logic [31:0] pmask = '0;
    logic [1:0]  mcount = '0;
    logic [4:0]  cur_fld = '0;
    logic [1:0]  fcount = '0;
    logic [31:0] facc = '0;
    logic        ignored = 1'b0;

    parsed_t     pending_results[$];
    logic [7:0]  msg_buf[$];
    int          items_sent = 0;
    int          mismatches = 0;
    int          cycle_count = 0;
    bit          src_gaps = 1'b0;
    bit          rx_gaps = 1'b0;
    int          hold_left = 0;
    int          stall_left = 0;

    always #6 clk = ~clk;

    // byte width of each field slot, zero past the defined ones
    function automatic logic [2:0] fld_width(input int idx);
        if (idx >= 22)
            return 3'd0;
        if (idx >= 16 && idx <= 18)
            return 3'd1;
        if (idx == 0 || idx == 1 || idx == 4 || idx == 7 || idx == 8)
            return 3'd2;
        return 3'd4;
    endfunction

    // first present and defined field at or after from
    function automatic int next_present(input int from);
        for (int i = from; i < 32; i++) begin
            if (i < NUM_FIELDS && fld_width(i) != 3'd0 && pmask[i])
                return i;
        end
        return NO_FIELD;
    endfunction

    task automatic open_fields();
        int nf;
        nf = next_present(0);
        fcount = '0;
        facc = '0;
        if (nf == NO_FIELD) begin
            parse_at = PH_DRAIN;
            cur_fld = '0;
        end
        else begin
            parse_at = PH_FLD;
            cur_fld = 5'(nf);
        end
    endtask

    // advance the mirror by one accepted byte and queue its results
    task automatic parse_byte(input logic [7:0] b, input logic eom);
        parsed_t fr;
        parsed_t sr;
        logic have_fld;
        logic [1:0] st;
        logic [2:0] sz;
        int nf;
        have_fld = 1'b0;
        st = ST_OK;
        fr = '0;
        case (parse_at)
            PH_CMD:
            begin
                ignored = 1'b0;
                pmask = '0;
                mcount = '0;
                if (b == sel_code)
                begin
                    parse_at = PH_HDR;
                    if (eom)
                        st = ST_SHORT;
                end
                else if (b == full_code)
                begin
                    pmask = '1;
                    open_fields();
                end
                else
                begin
                    ignored = 1'b1;
                    parse_at = PH_DRAIN;
                end
            end
            PH_HDR:
            begin
                pmask = {pmask[23:0], b};
                if (mcount == 2'd3)
                begin
                    mcount = '0;
                    open_fields();
                end
                else
                begin
                    mcount++;
                    if (eom)
                        st = ST_SHORT;
                end
            end
            PH_FLD:
            begin
                sz = fld_width(int'(cur_fld));
                facc = {facc[23:0], b};
                if (sz == 3'd0 || int'(fcount) + 1 >= int'(sz))
                begin
                    have_fld = 1'b1;
                    fr.kind = KIND_FIELD;
                    fr.index = cur_fld;
                    fr.raw = facc;
                    fr.nbytes = sz;
                    fr.status = ST_OK;
                    fr.last = !eom;
                    fcount = '0;
                    facc = '0;
                    nf = next_present(int'(cur_fld) + 1);
                    if (nf == NO_FIELD)
                    begin
                        parse_at = PH_DRAIN;
                        cur_fld = '0;
                    end
                    else
                    begin
                        cur_fld = 5'(nf);
                    end
                end
                else
                begin
                    fcount++;
                end
            end
            default:
            begin
            end
        endcase
        if (have_fld)
            pending_results.push_back(fr);
        // end of message: status result, then back to the command byte
        if (eom)
        begin
            sr = '0;
            sr.kind = KIND_STATUS;
            sr.status = ignored ? ST_IGNORED : st;
            sr.last = 1'b1;
            pending_results.push_back(sr);
            parse_at = PH_CMD;
            pmask = '0;
            mcount = '0;
            cur_fld = '0;
            fcount = '0;
            facc = '0;
            ignored = 1'b0;
        end
    endtask

    // one request on the message channel, with an optional idle burst first
    task automatic send_byte(input logic [7:0] b, input logic eom);
        int gap;
        if (src_gaps && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            msg_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        msg_ch.valid <= 1'b1;
        msg_ch.rx_byte <= b;
        msg_ch.end_of_message <= eom;
        @(posedge clk);
        while (!msg_ch.ready)
            @(posedge clk);
        parse_byte(b, eom);
        items_sent++;
    endtask

    task automatic send_buf();
        for (int i = 0; i < msg_buf.size(); i++)
            send_byte(msg_buf[i], i == msg_buf.size() - 1);
    endtask

    // stop sending and wait for every pending result, bounded
    task automatic settle();
        int waited;
        waited = 0;
        msg_ch.valid <= 1'b0;
        while (pending_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // write both command codes, block must be idle
    task automatic set_codes(input logic [7:0] full_val, input logic [7:0] sel_val);
        cfg_we <= 1'b1;
        cfg_index <= REG_FULL_SET;
        cfg_data <= full_val;
        @(posedge clk);
        cfg_index <= REG_SELECTIVE;
        cfg_data <= sel_val;
        @(posedge clk);
        cfg_we <= 1'b0;
        full_code = full_val;
        sel_code = sel_val;
    endtask

    function automatic logic [7:0] rand_byte();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic [31:0] random_mask();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return $urandom & $urandom & $urandom;
            2: return 32'h1 << $urandom_range(0, 31);
            3: return 32'hFFFF_FFFF;
            default: return $urandom & $urandom & 32'h003F_FFFF;
        endcase
    endfunction

    // mostly well-formed messages, some truncated, with trailing bytes or with an unknown command
    task automatic send_random_message();
        logic [31:0] mask;
        logic [7:0] cmd;
        int pick;
        int body;
        int shape;
        int cut;
        msg_buf.delete();
        body = 0;
        mask = '0;
        pick = $urandom_range(0, 99);
        if (pick < 10)
        begin
            cmd = full_code;
            mask = '1;
        end
        else if (pick < 88)
        begin
            cmd = sel_code;
            mask = random_mask();
        end
        else
        begin
            cmd = 8'($urandom);
            while (cmd == full_code || cmd == sel_code)
                cmd = 8'($urandom);
            body = $urandom_range(0, 6);
        end
        msg_buf.push_back(cmd);
        if (pick >= 10 && pick < 88)
        begin
            msg_buf.push_back(mask[31:24]);
            msg_buf.push_back(mask[23:16]);
            msg_buf.push_back(mask[15:8]);
            msg_buf.push_back(mask[7:0]);
        end
        if (pick < 88)
        begin
            for (int i = 0; i < NUM_FIELDS; i++)
                if (mask[i])
                    body += int'(fld_width(i));
        end
        repeat (body) msg_buf.push_back(rand_byte());
        shape = $urandom_range(0, 9);
        if (shape >= 8)
        begin
            cut = $urandom_range(1, msg_buf.size());
            while (msg_buf.size() > cut)
                void'(msg_buf.pop_back());
        end
        else if (shape == 7)
        begin
            repeat ($urandom_range(1, 3)) msg_buf.push_back(rand_byte());
        end
        send_buf();
    endtask

    // random messages until n_items more requests have gone in
    task automatic run_messages(input int n_items, input bit allow_idle, input bit recode);
        int stop_at;
        logic [7:0] f_val;
        logic [7:0] s_val;
        stop_at = items_sent + n_items;
        while (items_sent < stop_at)
        begin
            src_gaps = allow_idle && ($urandom_range(0, 3) != 0);
            rx_gaps = allow_idle && ($urandom_range(0, 3) != 0);
            send_random_message();
            if (recode && $urandom_range(0, 9) == 0)
            begin
                settle();
                f_val = 8'($urandom);
                s_val = 8'($urandom);
                if (s_val == f_val && $urandom_range(0, 3) != 0)
                    s_val = s_val + 8'd1;
                set_codes(f_val, s_val);
            end
        end
        settle();
    endtask

    task automatic test_directed_cases();
        src_gaps = 1'b0;
        rx_gaps = 1'b0;
        // unknown command, eom on the command byte
        msg_buf = '{8'h00};
        send_buf();
        // unknown command, a selective code inside is ignored
        msg_buf = '{8'hFF, sel_code};
        send_buf();
        // eom on the command byte, selective then full set
        msg_buf = '{sel_code};
        send_buf();
        msg_buf = '{full_code};
        send_buf();
        // header cut after one mask byte
        msg_buf = '{sel_code, 8'h00};
        send_buf();
        // fields 16 and 19, final byte completes a field and ends the message
        msg_buf = '{sel_code, 8'h00, 8'h09, 8'h00, 8'h00, 8'hFF,
                    8'hFF, 8'hFF, 8'hFF, 8'hFF};
        send_buf();
        // high mask bits ignored, field 21 cut short
        msg_buf = '{sel_code, 8'hFF, 8'hE4, 8'h00, 8'h00, 8'h00, 8'hFF};
        send_buf();
        // empty mask, trailing bytes drained
        msg_buf = '{sel_code, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F};
        send_buf();
        settle();
    endtask

    // result side held off while a full-set message streams in
    task automatic test_output_stall();
        src_gaps = 1'b0;
        rx_gaps = 1'b0;
        hold_left = 300;
        msg_buf.delete();
        msg_buf.push_back(full_code);
        repeat (69) msg_buf.push_back(rand_byte());
        send_buf();
        settle();
    endtask

    task automatic test_config_extremes();
        set_codes(8'h00, 8'hFF);
        run_messages(150, 1'b1, 1'b0);
        set_codes(8'hFF, 8'h00);
        run_messages(100, 1'b1, 1'b0);
    endtask

    // equal codes: the command byte takes the selective path
    task automatic test_equal_codes();
        set_codes(8'h80, 8'h80);
        msg_buf = '{8'h80};
        send_buf();
        run_messages(80, 1'b1, 1'b0);
        set_codes(FULL_SET_RESET, SELECTIVE_RESET);
    endtask

    task automatic test_random_traffic();
        run_messages(650, 1'b1, 1'b1);
        set_codes(FULL_SET_RESET, SELECTIVE_RESET);
    endtask

    task automatic test_quiet_tail();
        run_messages(170, 1'b0, 1'b0);
    endtask

    task automatic note_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, what, want, got);
    endtask

    // result receiver: random stall bursts plus a long hold on request
    always @(posedge clk)
    begin
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            res_ch.ready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            res_ch.ready <= 1'b0;
        end
        else if (rx_gaps && $urandom_range(0, 4) == 0)
        begin
            stall_left <= $urandom_range(0, 10);
            res_ch.ready <= 1'b0;
        end
        else
        begin
            res_ch.ready <= 1'b1;
        end
    end

    // compare each accepted result with the oldest expectation
    always @(posedge clk)
    begin
        parsed_t want;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                note_mismatch("unexpected result, kind", 32'h0, 32'(res_ch.result_kind));
            end
            else
            begin
                want = pending_results.pop_front();
                if (res_ch.result_kind !== want.kind)
                    note_mismatch("result_kind", 32'(want.kind), 32'(res_ch.result_kind));
                if (res_ch.field_index !== want.index)
                    note_mismatch("field_index", 32'(want.index), 32'(res_ch.field_index));
                if (res_ch.field_raw !== want.raw)
                    note_mismatch("field_raw", want.raw, res_ch.field_raw);
                if (res_ch.field_bytes !== want.nbytes)
                    note_mismatch("field_bytes", 32'(want.nbytes), 32'(res_ch.field_bytes));
                if (res_ch.message_status !== want.status)
                    note_mismatch("message_status", 32'(want.status),
                                  32'(res_ch.message_status));
                if (res_ch.last_result !== want.last)
                    note_mismatch("last_result", 32'(want.last), 32'(res_ch.last_result));
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_FULL_SET;
        cfg_data = 8'h00;
        msg_ch.valid = 1'b0;
        msg_ch.rx_byte = 8'h00;
        msg_ch.end_of_message = 1'b0;
        res_ch.ready = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_cases();
        test_output_stall();
        test_config_extremes();
        test_equal_codes();
        test_random_traffic();
        test_quiet_tail();

        if (pending_results.size() != 0)
        begin
            mismatches++;
            $display("%0t: results missing: expected %0d more, actual 0",
                     $time, pending_results.size());
        end
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
